[hdl/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
`default_nettype none
package mexp_pkg;

    // Fixed field widths of the block's interface.
    localparam int BASE_BITS = 63;
    localparam int EXP_W     = 63;
    localparam int RESULT_W  = 31;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    // Value of the modulus register after reset.
    localparam logic [30:0] MOD_RESET = 31'd998244353;

    // Register index of the modulus, as decoded from paddr[2].
    localparam logic REG_MODULUS = 1'b0;

    // Status of a bit-serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } ser_status_t;

endpackage
`default_nettype wire

[hdl/mexp_reduce.sv]
// Bit-serial reduction of the base modulo the modulus, one base bit per cycle.
`default_nettype none
module mexp_reduce #(
    parameter int W = 31
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [mexp_pkg::BASE_BITS-1:0]    value,
    input  wire logic [W-1:0]                      modulus,
    output mexp_pkg::ser_status_t                  status,
    output logic [W-1:0]                           remainder
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(BASE_BITS + 1);

    logic [BASE_BITS-1:0] shift_reg;
    logic [W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [W:0]           dbl;

    // Shift in the next base bit and subtract the modulus once if needed.
    always_comb
    begin
        dbl = {rem_reg, shift_reg[BASE_BITS-1]};
        if (dbl >= {1'b0, modulus})
        begin
            dbl = dbl - {1'b0, modulus};
        end
        rem_next = dbl[W-1:0];
    end

    // Sequencing of the serial pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(BASE_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= value;
            rem_reg   <= '0;
        end
        else if (run_reg)
        begin
            shift_reg <= {shift_reg[BASE_BITS-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule
`default_nettype wire

[hdl/mexp_mul.sv]
// Bit-serial modular multiplier: scans the multiplier MSB first, one bit per cycle.
`default_nettype none
module mexp_mul #(
    parameter int W = 31
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [W-1:0]      x,
    input  wire logic [W-1:0]      y,
    input  wire logic [W-1:0]      modulus,
    output mexp_pkg::ser_status_t  status,
    output logic [W-1:0]           product
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [W:0]       dbl;
    logic [W:0]       sum;

    // acc = 2*acc + bit*x, reduced by a compare-subtract after the doubling and again after the addition.
    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {1'b0, modulus})
        begin
            dbl = dbl - {1'b0, modulus};
        end
        sum = {1'b0, dbl[W-1:0]};
        if (y_reg[W-1])
        begin
            sum = sum + {1'b0, x_reg};
        end
        if (sum >= {1'b0, modulus})
        begin
            sum = sum - {1'b0, modulus};
        end
        acc_next = sum[W-1:0];
    end

    // Sequencing of the serial pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            y_reg   <= {y_reg[W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule
`default_nettype wire

[hdl/modular_exponentiation.sv]
// Top level of the modular exponentiation block: control, registers and APB port.
//
// Computes base^exponent mod modulus by right-to-left square-and-multiply. An item is
// accepted when start is high and busy is low; busy then stays high until the result
// appears on power_mod for exactly one cycle with done high, and the receiver cannot
// stall it. The next item can be accepted in the cycle after the result. The base is
// first reduced one bit per cycle over all 63 base bits, followed by a completion and a
// hand-off. Then each exponent bit costs one pass of the two bit-serial multipliers,
// which form the running product and the next square side by side: a start, the
// MOD_BITS multiplier bits in turn and a completion. A modulus below 2 gives 0 in the
// cycle after acceptance. The modulus register lies at byte address 0 and must be
// written only while busy is low.
`default_nettype none
module modular_exponentiation #(
    parameter int EXP_BITS = 63,
    parameter int MOD_BITS = 31
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [mexp_pkg::BASE_BITS-1:0]    base,
    input  wire logic [mexp_pkg::EXP_W-1:0]        exponent,
    output logic                                   done,
    output logic [mexp_pkg::RESULT_W-1:0]          power_mod,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mexp_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [mexp_pkg::PDATA_W-1:0]      pwdata,
    output logic [mexp_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);
    import mexp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_MULT   = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [MOD_BITS-1:0] mod_reg;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [MOD_BITS-1:0] prod_reg, prod_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;
    logic [MOD_BITS-1:0] result_reg, result_next;
    logic                red_start_next;
    logic                mul_start_reg, mul_start_next;

    ser_status_t         red_status;
    ser_status_t         pmul_status;
    ser_status_t         smul_status;
    logic [MOD_BITS-1:0] red_value;
    logic [MOD_BITS-1:0] pmul_value;
    logic [MOD_BITS-1:0] smul_value;
    logic                accept;
    logic                cfg_write;

    // Configuration port: single modulus register, writes complete in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MOD_RESET[MOD_BITS-1:0];
        end
        else if (cfg_write && (paddr[2] == REG_MODULUS))
        begin
            mod_reg <= pwdata[MOD_BITS-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MODULUS)
        begin
            prdata = PDATA_W'(mod_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Serial units: base reduction, running product lane and squaring lane.
    // The reduction unit loads the base at the accepting edge itself.
    mexp_reduce #(
        .W (MOD_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start_next),
        .value     (base),
        .modulus   (mod_reg),
        .status    (red_status),
        .remainder (red_value)
    );

    mexp_mul #(
        .W (MOD_BITS)
    ) u_mul_prod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .x       (prod_reg),
        .y       (sq_reg),
        .modulus (mod_reg),
        .status  (pmul_status),
        .product (pmul_value)
    );

    mexp_mul #(
        .W (MOD_BITS)
    ) u_mul_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .x       (sq_reg),
        .y       (sq_reg),
        .modulus (mod_reg),
        .status  (smul_status),
        .product (smul_value)
    );

    assign accept = start && !busy;

    // Sequencer over the exponent bits.
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        prod_next      = prod_reg;
        sq_next        = sq_reg;
        result_next    = result_reg;
        red_start_next = 1'b0;
        mul_start_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mod_reg < MOD_BITS'(2))
                    begin
                        result_next = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        exp_next       = exponent[EXP_BITS-1:0];
                        prod_next      = MOD_BITS'(1);
                        red_start_next = 1'b1;
                        state_next     = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (red_status.done)
                begin
                    sq_next = red_value;
                    if (exp_reg == '0)
                    begin
                        result_next = prod_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        mul_start_next = 1'b1;
                        state_next     = S_MULT;
                    end
                end
            end
            S_MULT:
            begin
                if (pmul_status.done && smul_status.done)
                begin
                    if (exp_reg[0])
                    begin
                        prod_next = pmul_value;
                    end
                    sq_next  = smul_value;
                    exp_next = exp_reg >> 1;
                    if ((exp_reg >> 1) == '0)
                    begin
                        result_next = exp_reg[0] ? pmul_value : prod_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        mul_start_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_start_reg <= mul_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        prod_reg   <= prod_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    // Result transfer lasts one cycle.
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign power_mod = RESULT_W'(result_reg);

    // Checks on the sequencing.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || accept))
        else $error("result without a preceding item");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mod_reg >= MOD_BITS'(2))) |-> (result_reg < mod_reg))
        else $error("result not reduced below the modulus");

    a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
        pmul_status.done == smul_status.done)
        else $error("multiplier lanes out of step");

endmodule
`default_nettype wire
